>>> sv/sws_pkg.sv
// shared types and constants of the sliding window z-score motion block
package sws_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int MAX_PIXELS = 16384;
    localparam int PIX_W      = 14;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 5;
    localparam int WADDR_W    = SLOT_W + PIX_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int PADDR_W    = 4;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    localparam logic [1:0] REG_WLEN = 2'd0;
    localparam logic [1:0] REG_FPIX = 2'd1;
    localparam logic [1:0] REG_ZTHR = 2'd2;

    localparam logic [4:0]  WLEN_RST = 5'd8;
    localparam logic [14:0] FPIX_RST = 15'd16384;
    localparam logic [7:0]  ZTHR_RST = 8'd40;

    typedef struct packed {
        logic        func;
        logic [13:0] pixel_index;
        logic [7:0]  pixel_y;
        logic [7:0]  pixel_u;
        logic [7:0]  pixel_v;
    } t_in_word;

    typedef struct packed {
        logic       motion;
        logic [4:0] frames_held;
    } t_out_word;

    typedef struct packed {
        logic [4:0]  window_len;
        logic [14:0] frame_pixels;
        logic [7:0]  z_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0][19:0] sq;
        logic [2:0][11:0] sum;
    } t_stat;

    typedef struct packed {
        logic                vld;
        logic                wr;
        logic                tst;
        logic                retire;
        logic [CNT_W-1:0]    cnt;
        logic [CNT_W-1:0]    held;
        logic [SLOT_W-1:0]   slot;
        logic [PIX_W-1:0]    pix;
        logic [2:0][7:0]     smp;
    } t_stage;

endpackage

>>> sv/sliding_window_zscore_motion.sv
// throughput: one word per cycle while the input word channel is not stalled; up to 8 words
// in flight, set by the output queue credit
// the statistics memory is read and written back in the cycle after, with forwarding
// reset: synchronous, active low; registers take their reset values and head and count clear
// after reset and after every write to the window, frame or threshold register a clearing
// pass zeroes the sums and stalls the input word channel
module sliding_window_zscore_motion (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  sws_pkg::t_in_word            i_in_word,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output sws_pkg::t_out_word           o_out_word,
    input  logic                         i_out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sws_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sws_pkg::*;

    t_cfg              cfg;
    logic              restart;
    logic              clr;
    logic [PIX_W-1:0]  clr_addr;
    t_stat             stat;
    logic              z_vld;
    t_out_word         z_word;

    logic [SLOT_W-1:0] r_head;
    logic [CNT_W-1:0]  r_cnt;
    logic [FIFO_AW:0]  r_pend;
    t_stage            r_s1;

    logic [SLOT_W-1:0] n_head;
    logic [CNT_W-1:0]  n_cnt;
    t_stage            n_s1;
    logic [CNT_W-1:0]  win_n;
    logic [14:0]       pix_p;
    logic              acc;
    logic              pop;
    logic              inr;
    logic              push;
    logic              last;

    sws_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .o_restart  (restart),
        .o_clr      (clr),
        .o_clr_addr (clr_addr)
    );

    assign o_in_stall = (r_pend == (FIFO_AW+1)'(FIFO_DEPTH)) || clr;
    assign acc        = i_in_valid & ~o_in_stall;
    assign pop        = o_out_valid & ~i_out_stall;

    always_comb begin
        if (cfg.window_len == '0) begin
            win_n = CNT_W'(1);
        end else if (cfg.window_len > CNT_W'(MAX_WINDOW)) begin
            win_n = CNT_W'(MAX_WINDOW);
        end else begin
            win_n = cfg.window_len;
        end
        if (cfg.frame_pixels == '0) begin
            pix_p = 15'd1;
        end else if (cfg.frame_pixels > 15'(MAX_PIXELS)) begin
            pix_p = 15'(MAX_PIXELS);
        end else begin
            pix_p = cfg.frame_pixels;
        end
    end

    assign inr  = {1'b0, i_in_word.pixel_index} < pix_p;
    assign push = (i_in_word.func == FUNC_PUSH);
    assign last = {1'b0, i_in_word.pixel_index} == (pix_p - 15'd1);

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (acc && push && inr && last) begin
            n_head = (({1'b0, r_head} + 1'b1) == win_n) ? '0 : r_head + 1'b1;
            if (r_cnt < win_n) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
        n_s1.vld    = acc;
        n_s1.wr     = acc & push & inr;
        n_s1.tst    = (i_in_word.func == FUNC_TEST) & inr & (r_cnt != '0);
        n_s1.retire = (r_cnt >= win_n);
        n_s1.cnt    = r_cnt;
        n_s1.held   = n_cnt;
        n_s1.slot   = r_head;
        n_s1.pix    = i_in_word.pixel_index;
        n_s1.smp    = {i_in_word.pixel_v, i_in_word.pixel_u, i_in_word.pixel_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
            r_s1   <= '0;
        end else begin
            if (restart) begin
                r_head <= '0;
                r_cnt  <= '0;
            end else begin
                r_head <= n_head;
                r_cnt  <= n_cnt;
            end
            r_pend <= r_pend + {{FIFO_AW{1'b0}}, acc} - {{FIFO_AW{1'b0}}, pop};
            r_s1   <= n_s1;
        end
    end

    sws_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (clr),
        .i_clr_addr (clr_addr),
        .i_rd_pix   (i_in_word.pixel_index),
        .i_rd_slot  (r_head),
        .i_s1       (r_s1),
        .o_stat     (stat)
    );

    sws_zpipe u_zpipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (r_s1),
        .i_stat  (stat),
        .i_z     (cfg.z_limit),
        .o_vld   (z_vld),
        .o_word  (z_word)
    );

    sws_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (z_vld),
        .i_data  (z_word),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_word)
    );

endmodule

>>> sv/sws_cfg.sv
// configuration registers, apb access and statistics clearing sweep
module sws_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sws_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sws_pkg::t_cfg                o_cfg,
    output logic                         o_restart,
    output logic                         o_clr,
    output logic [sws_pkg::PIX_W-1:0]    o_clr_addr
);
    import sws_pkg::*;

    t_cfg             r_cfg;
    logic             r_clr;
    logic [PIX_W-1:0] r_clr_addr;
    logic             wr;
    logic [1:0]       idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel & penable & pwrite;
    assign o_restart = wr & ((idx == REG_WLEN) || (idx == REG_FPIX) || (idx == REG_ZTHR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_len   <= WLEN_RST;
            r_cfg.frame_pixels <= FPIX_RST;
            r_cfg.z_limit      <= ZTHR_RST;
            r_clr              <= 1'b1;
            r_clr_addr         <= '0;
        end else begin
            if (wr) begin
                unique case (idx)
                    REG_WLEN: r_cfg.window_len   <= pwdata[4:0];
                    REG_FPIX: r_cfg.frame_pixels <= pwdata[14:0];
                    REG_ZTHR: r_cfg.z_limit      <= pwdata[7:0];
                    default:  ;
                endcase
            end
            if (o_restart) begin
                r_clr      <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr) begin
                if (r_clr_addr == PIX_W'(MAX_PIXELS - 1)) begin
                    r_clr <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_comb begin
        unique case (idx)
            REG_WLEN: prdata = {27'b0, r_cfg.window_len};
            REG_FPIX: prdata = {17'b0, r_cfg.frame_pixels};
            REG_ZTHR: prdata = {24'b0, r_cfg.z_limit};
            default:  prdata = '0;
        endcase
    end

    assign o_cfg      = r_cfg;
    assign o_clr      = r_clr;
    assign o_clr_addr = r_clr_addr;

endmodule

>>> sv/sws_store.sv
// window ring and statistics memories with read-modify-write and forwarding
module sws_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clr,
    input  logic [sws_pkg::PIX_W-1:0]   i_clr_addr,
    input  logic [sws_pkg::PIX_W-1:0]   i_rd_pix,
    input  logic [sws_pkg::SLOT_W-1:0]  i_rd_slot,
    input  sws_pkg::t_stage             i_s1,
    output sws_pkg::t_stat              o_stat
);
    import sws_pkg::*;

    t_stat           r_stat_mem [MAX_PIXELS];
    logic [2:0][7:0] r_win_mem  [MAX_WINDOW*MAX_PIXELS];

    t_stat           r_stat_rd;
    t_stat           r_stat_fwd;
    logic [2:0][7:0] r_win_rd;
    logic [2:0][7:0] r_win_fwd;
    logic            r_stat_hit;
    logic            r_win_hit;

    t_stat            cur;
    t_stat            stat_new;
    logic [2:0][7:0]  old;
    logic             stat_we;
    logic [PIX_W-1:0] stat_waddr;
    t_stat            stat_wdata;
    logic [7:0]       o_smp;
    logic [15:0]      o_sq;
    logic [15:0]      x_sq;

    assign cur = r_stat_hit ? r_stat_fwd : r_stat_rd;
    assign old = r_win_hit ? r_win_fwd : r_win_rd;

    always_comb begin
        stat_new = cur;
        o_smp    = '0;
        o_sq     = '0;
        x_sq     = '0;
        for (int c = 0; c < 3; c++) begin
            o_smp = i_s1.retire ? old[c] : 8'd0;
            o_sq  = o_smp * o_smp;
            x_sq  = i_s1.smp[c] * i_s1.smp[c];
            stat_new.sum[c] = cur.sum[c] - {4'b0, o_smp} + {4'b0, i_s1.smp[c]};
            stat_new.sq[c]  = cur.sq[c] - {4'b0, o_sq} + {4'b0, x_sq};
        end
    end

    assign stat_we    = i_clr | i_s1.wr;
    assign stat_waddr = i_clr ? i_clr_addr : i_s1.pix;
    assign stat_wdata = i_clr ? '0 : stat_new;

    always_ff @(posedge i_clk) begin
        if (stat_we) begin
            r_stat_mem[stat_waddr] <= stat_wdata;
        end
        r_stat_rd <= r_stat_mem[i_rd_pix];
        if (i_s1.wr) begin
            r_win_mem[{i_s1.slot, i_s1.pix}] <= i_s1.smp;
        end
        r_win_rd   <= r_win_mem[{i_rd_slot, i_rd_pix}];
        r_stat_fwd <= stat_new;
        r_win_fwd  <= i_s1.smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_hit <= 1'b0;
            r_win_hit  <= 1'b0;
        end else begin
            r_stat_hit <= i_s1.wr && (i_s1.pix == i_rd_pix);
            r_win_hit  <= i_s1.wr && (i_s1.pix == i_rd_pix) && (i_s1.slot == i_rd_slot);
        end
    end

    assign o_stat = cur;

endmodule

>>> sv/sws_zpipe.sv
// pipelined exact z-score threshold test
module sws_zpipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sws_pkg::t_stage     i_s1,
    input  sws_pkg::t_stat      i_stat,
    input  logic [7:0]          i_z,
    output logic                o_vld,
    output sws_pkg::t_out_word  o_word
);
    import sws_pkg::*;

    logic [2:0][13:0] r2_d;
    logic [2:0][24:0] r2_nq;
    logic [2:0][23:0] r2_ss;
    logic [CNT_W-1:0] r2_n;
    logic             r2_vld, r2_tst;
    logic [CNT_W-1:0] r2_held;

    logic [2:0][23:0] r3_d2;
    logic [2:0][24:0] r3_var;
    logic             r3_vld, r3_tst;
    logic [CNT_W-1:0] r3_held;
    logic [15:0]      r_zz;

    logic [2:0][40:0] r4_prod;
    logic [2:0][31:0] r4_lhs;
    logic             r4_vld, r4_tst;
    logic [CNT_W-1:0] r4_held;

    logic [2:0][13:0] d;
    logic [2:0][24:0] nq;
    logic [2:0][23:0] ss;
    logic [12:0]      nx;
    logic [2:0][23:0] d2;
    logic [2:0][24:0] vr;
    logic [25:0]      diff;
    logic [9:0]       nn;
    logic signed [13:0] ds;
    logic signed [27:0] dsq;
    logic [2:0][40:0] prod;
    logic             any;

    always_comb begin
        nx = '0;
        for (int c = 0; c < 3; c++) begin
            nx    = i_s1.cnt * i_s1.smp[c];
            d[c]  = {1'b0, nx} - {2'b0, i_stat.sum[c]};
            nq[c] = i_s1.cnt * i_stat.sq[c];
            ss[c] = i_stat.sum[c] * i_stat.sum[c];
        end
    end

    always_comb begin
        nn   = r2_n * r2_n;
        diff = '0;
        ds   = '0;
        dsq  = '0;
        for (int c = 0; c < 3; c++) begin
            diff  = {1'b0, r2_nq[c]} - {2'b0, r2_ss[c]};
            vr[c] = ($signed(diff) < $signed({16'b0, nn})) ? {15'b0, nn} : diff[24:0];
            ds    = $signed(r2_d[c]);
            dsq   = ds * ds;
            d2[c] = dsq[23:0];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = r_zz * r3_var[c];
        end
    end

    always_comb begin
        any = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if ({9'b0, r4_lhs[c]} > r4_prod[c]) begin
                any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_d    <= d;
        r2_nq   <= nq;
        r2_ss   <= ss;
        r2_n    <= i_s1.cnt;
        r2_tst  <= i_s1.tst;
        r2_held <= i_s1.held;
        r3_d2   <= d2;
        r3_var  <= vr;
        r3_tst  <= r2_tst;
        r3_held <= r2_held;
        r_zz    <= i_z * i_z;
        r4_prod <= prod;
        for (int c = 0; c < 3; c++) begin
            r4_lhs[c] <= {r3_d2[c], 8'b0};
        end
        r4_tst  <= r3_tst;
        r4_held <= r3_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r2_vld <= i_s1.vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    assign o_vld              = r4_vld;
    assign o_word.motion      = r4_tst & any;
    assign o_word.frames_held = r4_held;

endmodule

>>> sv/sws_ofifo.sv
// output word queue
module sws_ofifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sws_pkg::t_out_word  i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output sws_pkg::t_out_word  o_data
);
    import sws_pkg::*;

    t_out_word          r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{FIFO_AW{1'b0}}, i_push} - {{FIFO_AW{1'b0}}, i_pop};
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

>>> dv/testbench.sv
// self-checking testbench of the sliding window z-score motion block
`timescale 1ns / 1ps

module testbench;
    import sws_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_word            i_in_word = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_word           o_out_word;
    logic                i_out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    sliding_window_zscore_motion dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [4:0]    cfg_wlen;
    logic [14:0]   cfg_fpix;
    logic [7:0]    cfg_zthr;
    logic [23:0]   ring_store [int];
    logic [11:0]   ch_sum [3][MAX_PIXELS];
    logic [19:0]   ch_sq [3][MAX_PIXELS];
    int unsigned   head_slot;
    int unsigned   frame_count;
    logic [23:0]   bg_pixel [MAX_PIXELS];

    t_in_word      pending_words[$];
    t_out_word     expected_words[$];
    int            fails = 0;
    int            idle_left = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    bit            hold_req = 0;
    bit            quiet = 0;
    int            cycles = 0;

    function automatic int unsigned window_frames();
        if (cfg_wlen < 1) return 1;
        if (cfg_wlen > MAX_WINDOW) return MAX_WINDOW;
        return cfg_wlen;
    endfunction

    function automatic int unsigned frame_size();
        if (cfg_fpix < 1) return 1;
        if (cfg_fpix > MAX_PIXELS) return MAX_PIXELS;
        return cfg_fpix;
    endfunction

    function automatic void restart_background();
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < MAX_PIXELS; i++) begin
                ch_sum[c][i] = '0;
                ch_sq[c][i] = '0;
            end
        end
        head_slot = 0;
        frame_count = 0;
    endfunction

    function automatic bit retires_unwritten(t_in_word w);
        int at;
        at = (head_slot % MAX_WINDOW) * MAX_PIXELS + w.pixel_index;
        return w.func == FUNC_PUSH && w.pixel_index < frame_size()
            && frame_count >= window_frames() && !ring_store.exists(at);
    endfunction

    function automatic t_out_word predict_motion(t_in_word w);
        t_out_word     r;
        int unsigned   n, p, pix, at, s, q, o;
        logic [23:0]   smp;
        longint        ln, ls, lq, d, vr, z;
        n = window_frames();
        p = frame_size();
        pix = w.pixel_index;
        smp = {w.pixel_v, w.pixel_u, w.pixel_y};
        r = '0;
        if (pix < p) begin
            if (w.func == FUNC_PUSH) begin
                at = (head_slot % MAX_WINDOW) * MAX_PIXELS + pix;
                for (int c = 0; c < 3; c++) begin
                    s = ch_sum[c][pix];
                    q = ch_sq[c][pix];
                    if (frame_count >= n) begin
                        o = ring_store[at][c*8 +: 8];
                        s -= o;
                        q -= o * o;
                    end
                    s += smp[c*8 +: 8];
                    q += smp[c*8 +: 8] * smp[c*8 +: 8];
                    ch_sum[c][pix] = s[11:0];
                    ch_sq[c][pix] = q[19:0];
                end
                ring_store[at] = smp;
                if (pix == p - 1) begin
                    head_slot = (head_slot + 1) % n;
                    if (frame_count < n) frame_count++;
                end
            end else if (frame_count != 0) begin
                for (int c = 0; c < 3; c++) begin
                    ln = frame_count;
                    ls = ch_sum[c][pix];
                    lq = ch_sq[c][pix];
                    z = cfg_zthr;
                    d = ln * longint'(smp[c*8 +: 8]) - ls;
                    vr = ln * lq - ls * ls;
                    if (vr < ln * ln) vr = ln * ln;
                    if (d * d * 256 > z * z * vr) r.motion = 1'b1;
                end
            end
        end
        r.frames_held = frame_count[4:0];
        return r;
    endfunction

    task automatic queue_word(t_in_word w);
        if (retires_unwritten(w)) w.func = FUNC_TEST;
        pending_words.push_back(w);
        expected_words.push_back(predict_motion(w));
    endtask

    function automatic logic [7:0] near_value(logic [7:0] b, int spread);
        int v;
        v = int'(b) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic t_in_word pixel_word(logic func, int pix, bit far);
        t_in_word w;
        w.func = func;
        w.pixel_index = pix[13:0];
        if (far) begin
            w.pixel_y = 8'($urandom);
            w.pixel_u = 8'($urandom);
            w.pixel_v = 8'($urandom);
        end else begin
            w.pixel_y = near_value(bg_pixel[pix][7:0], 4);
            w.pixel_u = near_value(bg_pixel[pix][15:8], 4);
            w.pixel_v = near_value(bg_pixel[pix][23:16], 4);
        end
        return w;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WLEN: cfg_wlen = value[4:0];
            REG_FPIX: cfg_fpix = value[14:0];
            default:  cfg_zthr = value[7:0];
        endcase
        restart_background();
    endtask

    task automatic random_phase(int words, bit with_hold);
        int p, done;
        t_in_word w;
        p = frame_size();
        done = 0;
        if (with_hold) hold_req = 1;
        while (done < words) begin
            if (p <= 16 && $urandom_range(0, 9) < 8) begin
                // one frame of pushes in raster order, tests mixed in
                for (int i = 0; i < p; i++) begin
                    queue_word(pixel_word(FUNC_PUSH, i, $urandom_range(0, 9) == 0));
                    done++;
                    if ($urandom_range(0, 2) == 0) begin
                        queue_word(pixel_word(FUNC_TEST, $urandom_range(0, p - 1),
                                              $urandom_range(0, 1)));
                        done++;
                    end
                end
            end else begin
                w.func = 1'($urandom_range(0, 1));
                w.pixel_index = 14'($urandom_range(0, p > 16 ? MAX_PIXELS - 1 : 2 * p));
                w.pixel_y = 8'($urandom);
                w.pixel_u = 8'($urandom);
                w.pixel_v = 8'($urandom);
                if (p > 16 && $urandom_range(0, 1)) w.pixel_index = 14'(p - 1);
                queue_word(w);
                done++;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
                idle_left <= $urandom_range(0, 7);
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0 && o_out_valid) begin
            hold_req <= 0;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= hold_left > 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %p", o_out_word);
                fails++;
            end else begin
                exp_word = expected_words.pop_front();
                if (o_out_word.motion !== exp_word.motion) begin
                    $error("motion expected %0d actual %0d", exp_word.motion, o_out_word.motion);
                    fails++;
                end
                if (o_out_word.frames_held !== exp_word.frames_held) begin
                    $error("frames_held expected %0d actual %0d",
                           exp_word.frames_held, o_out_word.frames_held);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int wl [9] = '{1, 16, 0, 31, 5, 3, 12, 2, 7};
        int fp [9] = '{1, 4, 3, 2, 0, 20000, 6, 32767, 5};
        int zt [9] = '{0, 255, 24, 40, 16, 8, 200, 64, 40};
        t_in_word w;
        cfg_wlen = WLEN_RST;
        cfg_fpix = FPIX_RST;
        cfg_zthr = ZTHR_RST;
        restart_background();
        for (int i = 0; i < MAX_PIXELS; i++) bg_pixel[i] = 24'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty window, extremes, out-of-frame, full-size frame end
        queue_word('{FUNC_TEST, 14'd0, 8'd255, 8'd255, 8'd255});
        queue_word('{FUNC_PUSH, 14'd0, 8'd0, 8'd0, 8'd0});
        queue_word('{FUNC_PUSH, 14'd16383, 8'd255, 8'd255, 8'd255});
        queue_word('{FUNC_TEST, 14'd0, 8'd0, 8'd0, 8'd0});
        queue_word('{FUNC_TEST, 14'd0, 8'd255, 8'd0, 8'd0});
        queue_word('{FUNC_TEST, 14'd16383, 8'd255, 8'd255, 8'd255});
        queue_word('{FUNC_TEST, 14'd16383, 8'd0, 8'd255, 8'd0});
        queue_word('{FUNC_PUSH, 14'd16383, 8'd128, 8'd128, 8'd128});
        queue_word('{FUNC_TEST, 14'd16383, 8'd0, 8'd0, 8'd255});
        wait_idle();
        write_reg(REG_FPIX, 32'd2);
        queue_word('{FUNC_PUSH, 14'd2, 8'd9, 8'd9, 8'd9});
        queue_word('{FUNC_TEST, 14'd3, 8'd9, 8'd9, 8'd9});
        queue_word('{FUNC_PUSH, 14'd0, 8'd10, 8'd20, 8'd30});
        queue_word('{FUNC_PUSH, 14'd1, 8'd200, 8'd100, 8'd50});
        queue_word('{FUNC_TEST, 14'd0, 8'd10, 8'd20, 8'd30});
        queue_word('{FUNC_TEST, 14'd1, 8'd0, 8'd100, 8'd50});
        w = '{FUNC_PUSH, 14'd16383, 8'd1, 8'd1, 8'd1};
        queue_word(w);
        random_phase(40, 0);
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_WLEN, wl[ph]);
            write_reg(REG_FPIX, fp[ph]);
            write_reg(REG_ZTHR, zt[ph]);
            if (ph == 8) quiet = 1;
            random_phase(ph == 1 ? 200 : 100, ph == 1 || ph == 6);
            wait_idle();
        end

        if (fails == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/sws_pkg.sv
sv/sws_cfg.sv
sv/sws_store.sv
sv/sws_zpipe.sv
sv/sws_ofifo.sv
sv/sliding_window_zscore_motion.sv
dv/testbench.sv
